// ----- hdl/tts_pkg.sv -----
package tts_pkg;

  // Codes of the mode field of an input beat.
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  // Codes of the kind field of a result beat.
  localparam logic KIND_PLAY = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam logic [19:0] TICK_STEP_RESET = 20'd31250;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // One row of the tone table memory.
  typedef struct packed {
    logic [15:0] freq;
    logic [31:0] duration;
    logic [31:0] due;
  } entry_t;

  // Payload of one result beat.
  typedef struct packed {
    logic        kind;
    logic [15:0] out_freq;
    logic [31:0] out_duration_ms;
    logic [31:0] now_us;
  } result_t;

endpackage

// ----- hdl/tts_in_if.sv -----
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] tone_freq;
  logic [31:0] tone_duration_ms;
  logic [31:0] due_time_us;

  modport source (
    output valid, mode, tone_freq, tone_duration_ms, due_time_us,
    input  ready
  );
  modport sink (
    input  valid, mode, tone_freq, tone_duration_ms, due_time_us,
    output ready
  );
endinterface

// ----- hdl/tts_out_if.sv -----
interface tts_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] out_freq;
  logic [31:0] out_duration_ms;
  logic [31:0] now_us;

  modport source (
    output valid, kind, out_freq, out_duration_ms, now_us,
    input  ready
  );
  modport sink (
    input  valid, kind, out_freq, out_duration_ms, now_us,
    output ready
  );
endinterface

// ----- hdl/timed_tone_scheduler.sv -----
// Channel   Dir  Handshake            Payload
// in_ch     in   valid/ready          mode, tone_freq, tone_duration_ms, due_time_us
// out_ch    out  valid/ready          kind, out_freq, out_duration_ms, now_us
// cfg       in   cfg_we, no wait      cfg_data = tick_step_us
//
// An add beat leaves the block idle and ready for the next input beat; a stop beat passes
// through the emit state first. A tick beat scans the whole table, then after a pick also
// passes through the emit state. One table row is read per cycle through the single read
// port of the tone memory, and each returned row is evaluated from a registered read.
// Reset is synchronous and active low; it clears the valid bits, pointer and time at once.
// A result beat waits in the output register; input beats are still taken while it waits,
// and only a second result stalls the block until out_ch.ready frees the register.
module timed_tone_scheduler
  import tts_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tts_in_if.sink      in_ch,
  tts_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  // Control state.
  state_t          state_r, state_nxt;
  logic [IDXW-1:0] write_slot_r;
  logic [IDXW-1:0] scan_addr_r;
  logic            issue_r;
  logic            rd_vld_r;
  logic [IDXW-1:0] rd_idx_r;
  logic [SLOTS-1:0] valid_r;
  logic [31:0]     now_r;
  logic [19:0]     tick_step_r;
  logic            have_r;
  logic            out_valid_r;

  // Payload registers.
  logic [31:0]     last_r;
  logic [15:0]     pick_freq_r;
  logic [31:0]     pick_dur_r;
  logic            kind_r;
  result_t         out_data_r;
  entry_t          rd_data_r;

  // The tone table: one write port for add beats, one read port for the scan.
  entry_t mem [SLOTS];

  logic        in_fire;
  logic        is_add, is_tick, is_stop;
  logic        hit;
  logic        scan_done;
  logic        out_free;
  logic        emit_load;
  logic [32:0] time_sum;
  logic [31:0] time_nxt;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign is_add  = in_fire && (in_ch.mode == MODE_ADD);
  assign is_tick = in_fire && (in_ch.mode == MODE_TICK);
  assign is_stop = in_fire && (in_ch.mode == MODE_STOP);

  // Saturating advance of the time counter on a tick.
  assign time_sum = {1'b0, now_r} + 33'(tick_step_r);
  assign time_nxt = time_sum[32] ? TIME_MAX : time_sum[31:0];

  // A row returned by the memory is a pick when it is still valid, already due and later
  // than every pick so far in this scan. A row due at zero can never pass the last test.
  assign hit = rd_vld_r && valid_r[rd_idx_r] && (rd_data_r.due <= now_r) &&
               (rd_data_r.due > last_r);
  assign scan_done = rd_vld_r && (rd_idx_r == LAST_IDX);

  assign out_free  = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_tick) begin
          state_nxt = ST_SCAN;
        end else if (is_stop) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = (have_r || hit) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ch.ready = 1'b0;
    emit_load   = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SCAN: ;
      ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_slot_r <= '0;
      scan_addr_r  <= '0;
      issue_r      <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_idx_r     <= '0;
      valid_r      <= '0;
      now_r        <= '0;
      tick_step_r  <= TICK_STEP_RESET;
      have_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        tick_step_r <= cfg_data;
      end

      if (is_add) begin
        valid_r[write_slot_r] <= 1'b1;
        write_slot_r <= (write_slot_r == LAST_IDX) ? '0 : write_slot_r + 1'b1;
      end

      if (is_stop) begin
        valid_r <= '0;
      end

      // Scan sequencer: issue one read address per cycle, then evaluate the returned row.
      if (is_tick) begin
        now_r       <= time_nxt;
        scan_addr_r <= '0;
        issue_r     <= 1'b1;
        have_r      <= 1'b0;
      end else if (state_r == ST_SCAN && issue_r) begin
        if (scan_addr_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          scan_addr_r <= scan_addr_r + 1'b1;
        end
      end

      rd_vld_r <= (state_r == ST_SCAN) && issue_r;
      rd_idx_r <= scan_addr_r;

      // A pick is consumed at once, so an earlier pick beaten later in the scan is lost.
      if (hit) begin
        valid_r[rd_idx_r] <= 1'b0;
        have_r <= 1'b1;
      end

      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pick and result payload.
  always_ff @(posedge clk) begin
    if (is_tick) begin
      last_r <= '0;
      kind_r <= KIND_PLAY;
    end else if (is_stop) begin
      kind_r      <= KIND_STOP;
      pick_freq_r <= '0;
      pick_dur_r  <= '0;
    end
    if (hit) begin
      last_r      <= rd_data_r.due;
      pick_freq_r <= rd_data_r.freq;
      pick_dur_r  <= rd_data_r.duration;
    end
    if (emit_load) begin
      out_data_r.kind            <= kind_r;
      out_data_r.out_freq        <= pick_freq_r;
      out_data_r.out_duration_ms <= pick_dur_r;
      out_data_r.now_us          <= now_r;
    end
  end

  // Tone table memory, registered read.
  always_ff @(posedge clk) begin
    if (is_add) begin
      mem[write_slot_r] <= '{freq: in_ch.tone_freq, duration: in_ch.tone_duration_ms,
                             due: in_ch.due_time_us};
    end
    rd_data_r <= mem[scan_addr_r];
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = out_data_r.kind;
  assign out_ch.out_freq        = out_data_r.out_freq;
  assign out_ch.out_duration_ms = out_data_r.out_duration_ms;
  assign out_ch.now_us          = out_data_r.now_us;

  // A tick always starts a scan.
  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |=> state_r == ST_SCAN)
    else $error("tick did not start a scan");

  // Time never runs backward.
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    now_r >= $past(now_r))
    else $error("time counter decreased");

  // A picked row is invalidated in the next cycle.
  a_pick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> !valid_r[$past(rd_idx_r)])
    else $error("picked entry still valid");

  // Leaving the emit state always leaves a result in the output register.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> out_valid_r)
    else $error("emit did not load the output register");

endmodule
